// ===== src/bpu_pkg.sv =====
package bpu_pkg;

  // palette depth and address width
  localparam int unsigned PALETTE_ENTRIES = 256;
  localparam int unsigned PAL_AW = (PALETTE_ENTRIES > 1) ? $clog2(PALETTE_ENTRIES) : 1;
  localparam logic [8:0] PAL_LIMIT = 9'(PALETTE_ENTRIES);

  // pixel_mode register codes
  localparam logic [2:0] MODE_1BPP   = 3'd0;
  localparam logic [2:0] MODE_2BPP   = 3'd1;
  localparam logic [2:0] MODE_4BPP   = 3'd2;
  localparam logic [2:0] MODE_8BPP   = 3'd3;
  localparam logic [2:0] MODE_RGB555 = 3'd4;
  localparam logic [2:0] MODE_BGR24  = 3'd5;
  localparam logic [2:0] MODE_RESET  = MODE_BGR24;

  // tuser code for the kind of an input item
  localparam logic ACT_LOAD  = 1'b0;

  // what one sub-item does as it moves down the pipe
  typedef enum logic [2:0] {
    OP_LOAD  = 3'd0,
    OP_INDEX = 3'd1,
    OP_RGB   = 3'd2,
    OP_PASS  = 3'd3,
    OP_NONE  = 3'd4
  } op_e;

  typedef struct packed {
    logic              we;
    logic [PAL_AW-1:0] addr;
    logic [23:0]       data;
  } pal_wr_t;

  typedef struct packed {
    logic              re;
    logic [PAL_AW-1:0] addr;
  } pal_rd_t;

endpackage

// ===== src/bitmap_pixel_unpacker.sv =====
// Converts bitmap pixel items to blue/green/red bytes in a three-stage pipeline: an expander
// register, the palette read, and the output register. An indexed byte at 1, 2, 4 or 8 bpp
// yields 8, 4, 2 or 1 pixels, one per cycle unless stalled, with tlast on the last; RGB555
// and 24-bit items yield one pixel each; palette loads (tuser 0) and pixel items in modes
// six and seven yield nothing. The expander stage, which issues one palette read per cycle
// unless stalled, sets the rate and takes the next item only as it issues the last sub-item
// of the current one. The first pixel passes the expander, read and output registers before
// it is valid on the output. Palette entries are undefined until loaded.
module bitmap_pixel_unpacker
  import bpu_pkg::*;
(
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_wdata_i,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [55:0] s_axis_tdata,  // palette_index[7:0], palette_color[31:8], pixel_data[55:32]
  input  logic        s_axis_tuser,  // action
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,  // blue[7:0], green[15:8], red[23:16]
  output logic        m_axis_tlast
);

  logic [2:0] mode_q;

  // expander stage
  logic        s0_v_q;
  op_e         s0_op_q, acc_op;
  logic [1:0]  s0_bsel_q;
  logic [2:0]  s0_cnt_q, acc_cnt;
  logic [7:0]  s0_sh_q, sh_d, fld;
  logic [7:0]  s0_pidx_q;
  logic [23:0] s0_pcol_q;
  logic [23:0] s0_data_q;

  // read stage
  logic        s1_v_q;
  op_e         s1_op_q;
  logic        s1_oob_q;
  logic        s1_last_q;
  logic [23:0] s1_data_q;
  logic [23:0] pal_rdata;

  // output stage
  logic        out_v_q;
  logic [23:0] out_data_q, out_d;
  logic        out_last_q;

  logic out_en, s1_en, accept, emit, s0_final, s1_v_d;
  pal_wr_t pal_wr;
  pal_rd_t pal_rd;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q <= MODE_RESET;
    end else if (cfg_we_i) begin
      mode_q <= cfg_wdata_i;
    end
  end

  assign out_en   = !out_v_q || m_axis_tready;
  assign s1_en    = !s1_v_q || out_en;
  assign emit     = s0_v_q && s1_en;
  assign s0_final = (s0_cnt_q == 3'd0);
  assign s_axis_tready = !s0_v_q || (s1_en && s0_final);
  assign accept   = s_axis_tvalid && s_axis_tready;

  always_comb begin
    acc_op  = OP_NONE;
    acc_cnt = 3'd0;
    if (s_axis_tuser == ACT_LOAD) begin
      acc_op = OP_LOAD;
    end else begin
      case (mode_q)
        MODE_1BPP:   begin acc_op = OP_INDEX; acc_cnt = 3'd7; end
        MODE_2BPP:   begin acc_op = OP_INDEX; acc_cnt = 3'd3; end
        MODE_4BPP:   begin acc_op = OP_INDEX; acc_cnt = 3'd1; end
        MODE_8BPP:   begin acc_op = OP_INDEX; acc_cnt = 3'd0; end
        MODE_RGB555: acc_op = OP_RGB;
        MODE_BGR24:  acc_op = OP_PASS;
        default:     acc_op = OP_NONE;
      endcase
    end
  end

  // top field of the shifting byte, most significant field first
  always_comb begin
    case (s0_bsel_q)
      2'd0:    begin fld = {7'd0, s0_sh_q[7]};   sh_d = {s0_sh_q[6:0], 1'b0}; end
      2'd1:    begin fld = {6'd0, s0_sh_q[7:6]}; sh_d = {s0_sh_q[5:0], 2'b0}; end
      2'd2:    begin fld = {4'd0, s0_sh_q[7:4]}; sh_d = {s0_sh_q[3:0], 4'b0}; end
      default: begin fld = s0_sh_q;              sh_d = 8'd0;                 end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s0_v_q   <= 1'b0;
      s0_cnt_q <= 3'd0;
    end else if (accept) begin
      s0_v_q   <= 1'b1;
      s0_cnt_q <= acc_cnt;
    end else if (emit) begin
      if (s0_final) begin
        s0_v_q <= 1'b0;
      end else begin
        s0_cnt_q <= s0_cnt_q - 3'd1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      s0_op_q   <= acc_op;
      s0_bsel_q <= mode_q[1:0];
      s0_sh_q   <= s_axis_tdata[39:32];
      s0_pidx_q <= s_axis_tdata[7:0];
      s0_pcol_q <= s_axis_tdata[31:8];
      s0_data_q <= s_axis_tdata[55:32];
    end else if (emit) begin
      s0_sh_q <= sh_d;
    end
  end

  // loads write the palette in order with lookups, both at this point of the pipe
  assign pal_wr.we   = emit && (s0_op_q == OP_LOAD) && ({1'b0, s0_pidx_q} < PAL_LIMIT);
  assign pal_wr.addr = s0_pidx_q[PAL_AW-1:0];
  assign pal_wr.data = s0_pcol_q;
  assign pal_rd.re   = emit && (s0_op_q == OP_INDEX);
  assign pal_rd.addr = fld[PAL_AW-1:0];

  bpu_palette u_palette (
    .clk_i   (clk_i),
    .wr_i    (pal_wr),
    .rd_i    (pal_rd),
    .rdata_o (pal_rdata)
  );

  assign s1_v_d = emit && (s0_op_q == OP_INDEX || s0_op_q == OP_RGB || s0_op_q == OP_PASS);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_v_q <= 1'b0;
    end else if (s1_en) begin
      s1_v_q <= s1_v_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit) begin
      s1_op_q   <= s0_op_q;
      s1_oob_q  <= ({1'b0, fld} >= PAL_LIMIT);
      s1_last_q <= s0_final;
      s1_data_q <= s0_data_q;
    end
  end

  always_comb begin
    case (s1_op_q)
      OP_INDEX: out_d = s1_oob_q ? 24'd0 : pal_rdata;
      OP_RGB:   out_d = {s1_data_q[14:10], 3'b0,
                         s1_data_q[9:8], s1_data_q[7:5], 3'b0,
                         s1_data_q[4:0], 3'b0};
      default:  out_d = s1_data_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (out_en) begin
      out_v_q <= s1_v_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_en && s1_v_q) begin
      out_data_q <= out_d;
      out_last_q <= s1_last_q;
    end
  end

  assign m_axis_tvalid = out_v_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tlast  = out_last_q;

  a_free_ready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !s0_v_q |-> s_axis_tready)
    else $error("expander empty but input not ready");

  a_ready_final: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s0_v_q && s_axis_tready) |-> (s0_final && s1_en))
    else $error("input taken before expander finished");

  a_s1_to_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (s1_v_q && out_en) |=> m_axis_tvalid)
    else $error("read stage result lost");

  a_index_read: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (emit && s0_op_q == OP_INDEX) |=> (s1_v_q && s1_op_q == OP_INDEX))
    else $error("palette lookup not tracked");

endmodule

// ===== src/bpu_palette.sv =====
module bpu_palette
  import bpu_pkg::*;
(
  input  logic        clk_i,
  input  pal_wr_t     wr_i,
  input  pal_rd_t     rd_i,
  output logic [23:0] rdata_o
);

  logic [23:0] mem_q [PALETTE_ENTRIES];
  logic [23:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (wr_i.we) begin
      mem_q[wr_i.addr] <= wr_i.data;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_i.re) begin
      rdata_q <= mem_q[rd_i.addr];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== sim/bitmap_pixel_unpacker_tb.sv =====
`timescale 1ns / 100ps

module bitmap_pixel_unpacker_tb;
  import bpu_pkg::*;

  // codes the block leaves undefined: pixel items are dropped
  localparam logic [2:0] MODE_UNDEF6 = 3'd6;
  localparam logic [2:0] MODE_UNDEF7 = 3'd7;
  localparam int unsigned STALL_LIMIT = 2000;
  localparam int unsigned SINK_HOLD_CYCLES = 300;

  typedef struct packed {
    logic        action;
    logic [7:0]  idx;
    logic [23:0] color;
    logic [23:0] data;
  } pix_item_t;

  typedef struct packed {
    logic [7:0] blue;
    logic [7:0] green;
    logic [7:0] red;
    logic       last;
  } pixel_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        cfg_we_i = 1'b0;
  logic [2:0]  cfg_wdata_i = MODE_RESET;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [55:0] s_axis_tdata = '0;  // palette_index[7:0], palette_color[31:8], pixel_data[55:32]
  logic        s_axis_tuser = 1'b0;  // action
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;  // blue[7:0], green[15:8], red[23:16]
  logic        m_axis_tlast;

  bitmap_pixel_unpacker dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we_i),
    .cfg_wdata_i   (cfg_wdata_i),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast)
  );

  pix_item_t   item_q[$];
  pixel_t      pixel_q[$];
  pix_item_t   cur_item;
  logic [23:0] palette[256];
  bit          gen_written[256];
  logic [2:0]  cur_mode = MODE_RESET;
  int unsigned src_idle_pct = 33;
  int unsigned sink_idle_pct = 33;
  bit          sink_hold_req = 1'b0;
  int unsigned sink_hold_left = 0;
  int unsigned stall_cycles = 0;
  int unsigned fail_cnt = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // expected pixels for one accepted item; a load updates the model palette instead
  task automatic expand_pixel_item(input pix_item_t it);
    int     bpp;
    int     n;
    int     fidx;
    logic [23:0] col;
    logic [7:0]  b0;
    logic [7:0]  b1;
    pixel_t px;
    if (it.action == ACT_LOAD) begin
      if (it.idx < PALETTE_ENTRIES) palette[it.idx] = it.color;
      return;
    end
    case (cur_mode)
      MODE_1BPP, MODE_2BPP, MODE_4BPP, MODE_8BPP: begin
        bpp = 1 << cur_mode;
        n = 8 / bpp;
        for (int k = 0; k < n; k++) begin
          fidx = (it.data[7:0] >> (8 - (k + 1) * bpp)) & ((1 << bpp) - 1);
          col = (fidx < PALETTE_ENTRIES) ? palette[fidx] : 24'h0;
          px = '{blue: col[7:0], green: col[15:8], red: col[23:16], last: (k == n - 1)};
          pixel_q.push_back(px);
        end
      end
      MODE_RGB555: begin
        b0 = it.data[7:0];
        b1 = it.data[15:8];
        px = '{blue: {b0[4:0], 3'b000}, green: {b1[1:0], b0[7:5], 3'b000},
               red: {b1[6:2], 3'b000}, last: 1'b1};
        pixel_q.push_back(px);
      end
      MODE_BGR24: begin
        px = '{blue: it.data[7:0], green: it.data[15:8], red: it.data[23:16], last: 1'b1};
        pixel_q.push_back(px);
      end
      default: ;
    endcase
  endtask

  // source side
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (s_axis_tvalid && s_axis_tready) expand_pixel_item(cur_item);
      if (!s_axis_tvalid || s_axis_tready) begin
        if (item_q.size() != 0 && $urandom_range(99) >= src_idle_pct) begin
          cur_item = item_q.pop_front();
          s_axis_tvalid <= 1'b1;
          s_axis_tdata <= {cur_item.data, cur_item.color, cur_item.idx};
          s_axis_tuser <= cur_item.action;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // sink side and checker
  always @(posedge clk_i) begin
    pixel_t want;
    if (rst_ni) begin
      if (m_axis_tvalid && m_axis_tready) begin
        if (pixel_q.size() == 0) begin
          $error("unexpected pixel %h last %b", m_axis_tdata, m_axis_tlast);
          fail_cnt++;
        end else begin
          want = pixel_q.pop_front();
          if (m_axis_tdata[7:0] !== want.blue) begin
            $error("blue: expected %h, got %h", want.blue, m_axis_tdata[7:0]);
            fail_cnt++;
          end
          if (m_axis_tdata[15:8] !== want.green) begin
            $error("green: expected %h, got %h", want.green, m_axis_tdata[15:8]);
            fail_cnt++;
          end
          if (m_axis_tdata[23:16] !== want.red) begin
            $error("red: expected %h, got %h", want.red, m_axis_tdata[23:16]);
            fail_cnt++;
          end
          if (m_axis_tlast !== want.last) begin
            $error("last_of_run: expected %b, got %b", want.last, m_axis_tlast);
            fail_cnt++;
          end
        end
      end
      if (sink_hold_req) begin
        sink_hold_left = SINK_HOLD_CYCLES;
        sink_hold_req = 1'b0;
      end
      if (sink_hold_left > 0) begin
        sink_hold_left--;
        m_axis_tready <= 1'b0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= sink_idle_pct);
      end
    end
  end

  always @(posedge clk_i) begin
    if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      stall_cycles = 0;
    end else if (++stall_cycles >= STALL_LIMIT) begin
      $display("Test completed with failures");
      $finish;
    end
  end

  task automatic push_load(input logic [7:0] idx, input logic [23:0] color);
    if (idx < PALETTE_ENTRIES) gen_written[idx] = 1'b1;
    item_q.push_back('{action: ~ACT_LOAD, idx: idx, color: color, data: 24'($urandom)});
    item_q[$].action = ACT_LOAD;
  endtask

  task automatic push_pixel(input logic [23:0] data);
    item_q.push_back('{action: ~ACT_LOAD, idx: 8'($urandom), color: 24'($urandom), data: data});
  endtask

  // byte whose every field points at a loaded entry
  function automatic logic [7:0] pick_indexed_byte(input logic [2:0] mode);
    int bpp;
    int v;
    logic [7:0] b;
    bpp = 1 << mode;
    b = '0;
    for (int k = 0; k < 8 / bpp; k++) begin
      v = 0;
      for (int t = 0; t < 16; t++) begin
        v = $urandom_range((1 << bpp) - 1);
        if (gen_written[v]) break;
      end
      if (!gen_written[v]) v = 0;
      b = (b << bpp) | 8'(v);
    end
    return b;
  endfunction

  // everything in flight has come back, loads included
  task automatic wait_drained();
    do @(negedge clk_i); while (item_q.size() != 0 || s_axis_tvalid || pixel_q.size() != 0);
    repeat (8) @(negedge clk_i);
  endtask

  task automatic set_mode(input logic [2:0] mode);
    wait_drained();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= mode;
    cur_mode = mode;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  task automatic run_phase(input logic [2:0] mode, input int n, input int load_pct,
                           input bit hold_sink, input bit no_idle);
    logic [23:0] d;
    set_mode(mode);
    if (no_idle) begin
      src_idle_pct = 0;
      sink_idle_pct = 0;
    end
    if (hold_sink) sink_hold_req = 1'b1;
    repeat (n) begin
      if ($urandom_range(99) < load_pct) begin
        push_load(($urandom_range(1) != 0) ? 8'($urandom_range(15)) : 8'($urandom),
                  24'($urandom));
      end else begin
        d = 24'($urandom);
        if (mode <= MODE_8BPP) d[7:0] = pick_indexed_byte(mode);
        push_pixel(d);
      end
    end
    wait_drained();
    src_idle_pct = 33;
    sink_idle_pct = 33;
  endtask

  initial begin
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // passthrough at the reset mode, then palette extremes
    push_pixel(24'h000000);
    push_pixel(24'hFFFFFF);
    push_load(8'd0, 24'h000000);
    push_load(8'd255, 24'hFFFFFF);
    push_load(8'd1, 24'($urandom));
    push_load(8'd2, 24'($urandom));
    push_load(8'd3, 24'($urandom));
    push_load(8'd15, 24'($urandom));
    set_mode(MODE_1BPP);
    push_pixel({16'($urandom), 8'h5A});
    set_mode(MODE_2BPP);
    push_pixel({16'($urandom), 8'h1B});
    set_mode(MODE_4BPP);
    push_pixel({16'($urandom), 8'hF0});
    set_mode(MODE_8BPP);
    push_pixel({16'($urandom), 8'hFF});
    push_pixel({16'($urandom), 8'h00});
    // rgb555: all ones, top bit alone, all but the top bit
    set_mode(MODE_RGB555);
    push_pixel(24'h00FFFF);
    push_pixel({8'($urandom), 16'h8000});
    push_pixel({8'($urandom), 16'h7FFF});
    // undefined modes drop pixel items
    set_mode(MODE_UNDEF6);
    push_pixel(24'($urandom));
    set_mode(MODE_UNDEF7);
    push_pixel(24'($urandom));

    run_phase(MODE_1BPP, 40, 25, 1'b1, 1'b0);
    run_phase(MODE_2BPP, 35, 25, 1'b0, 1'b0);
    run_phase(MODE_4BPP, 35, 30, 1'b0, 1'b0);
    run_phase(MODE_8BPP, 50, 40, 1'b0, 1'b0);
    run_phase(MODE_RGB555, 40, 10, 1'b0, 1'b0);
    run_phase(MODE_BGR24, 40, 10, 1'b0, 1'b1);
    run_phase(MODE_UNDEF7, 6, 50, 1'b0, 1'b0);
    run_phase(MODE_8BPP, 40, 25, 1'b0, 1'b0);
    run_phase(MODE_1BPP, 30, 20, 1'b0, 1'b1);
    run_phase(MODE_4BPP, 30, 25, 1'b0, 1'b0);
    run_phase(MODE_UNDEF6, 4, 50, 1'b0, 1'b0);
    run_phase(MODE_BGR24, 20, 10, 1'b0, 1'b0);

    if (fail_cnt == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
